### hw/rtl/bounded_set_table_top_macros.svh
// assertion macros shared by the set table checker
// no dependencies; included by bst_checker.sv
`ifndef BOUNDED_SET_TABLE_TOP_MACROS_SVH
`define BOUNDED_SET_TABLE_TOP_MACROS_SVH

// same-cycle implication, muted while reset is high
`define BST_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("set table check failed");

// next-cycle implication, muted while reset is high
`define BST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("set table check failed");

`endif

### hw/rtl/bst_pkg.sv
// shared types and constants of the bounded set table
// no dependencies; used by bounded_set_table_top and bst_checker
package bst_pkg;

   // default table depth
   localparam int MAX_ENTRIES_DEFAULT = 16;

   // field widths
   localparam int VALUE_W    = 32;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;
   localparam int CAPACITY_W = 5;

   // capacity after reset
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_FULL   = 3'd1,
      STATUS_DUP    = 3'd2,
      STATUS_EMPTY  = 3'd3,
      STATUS_ABSENT = 3'd4
   } status_type;

endpackage

### hw/rtl/bounded_set_table_top.sv
// bounded set table: distinct 32-bit values held in one synchronous memory
// depends on bst_pkg
//
// usage
// - request channel (req_valid / req_stall, req_cmd, req_value) takes one
//   command at a time: insert, remove or membership query of a value
// - response channel (rsp_valid / rsp_stall) returns status, found flag
//   and the entry count after the command, one transfer per request
// - csr_write_en / csr_write_data set the capacity; write only while idle
// - every command scans the held entries through the single memory read
//   port, one entry per cycle; the response is registered once the scan
//   has ended, and only then is the next request taken
// - a remove moves the last entry into the freed slot, so the memory is
//   written at most once per command
// - the response sits in an output register: a new request is taken while
//   it waits, and a stalled response holds until rsp_stall falls
// - reset empties the table and sets the capacity to 16; memory contents
//   are not cleared, only slots below the count are ever read
module bounded_set_table_top #(
   parameter int MAX_ENTRIES = bst_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bst_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [bst_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bst_pkg::STATUS_W-1:0]      rsp_status,
   output logic                              rsp_found,
   output logic [bst_pkg::COUNT_W-1:0]       rsp_count,
   input  logic                              csr_write_en,
   input  logic [bst_pkg::CAPACITY_W-1:0]    csr_write_data
);

   localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int LIMW = (CW > bst_pkg::CAPACITY_W) ? CW : bst_pkg::CAPACITY_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   logic [bst_pkg::CAPACITY_W-1:0]  capacity_ff;
   logic [CW-1:0]                   count_ff, count_in;
   logic [bst_pkg::CMD_W-1:0]       cmd_ff;
   logic [bst_pkg::VALUE_W-1:0]     value_ff;
   logic [CW-1:0]                   rd_idx_ff, rd_idx_in;
   logic                            rd_pend_ff, rd_pend_in;
   logic [AW-1:0]                   cmp_idx_ff;
   logic [bst_pkg::VALUE_W-1:0]     rd_data_ff;
   logic [bst_pkg::VALUE_W-1:0]     last_data_ff;
   logic                            hit_ff;
   logic [AW-1:0]                   pos_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bst_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                            rsp_found_ff;
   logic [bst_pkg::COUNT_W-1:0]     rsp_count_ff;

   logic [bst_pkg::VALUE_W-1:0]     entry_mem [MAX_ENTRIES];

   logic                            req_fire;
   logic                            done_fire;
   logic                            rd_en;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic [bst_pkg::VALUE_W-1:0]     mem_wdata;
   logic [LIMW-1:0]                 limit;
   logic                            full;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rd_en     = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);

   // capacity saturates at the table depth
   assign limit = (LIMW'(capacity_ff) > LIMW'(MAX_ENTRIES)) ? LIMW'(MAX_ENTRIES)
                                                             : LIMW'(capacity_ff);
   assign full  = (LIMW'(count_ff) >= limit);

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bst_pkg::CAPACITY_RESET;
      end else if (csr_write_en) begin
         capacity_ff <= csr_write_data;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_idx_ff[AW-1:0]];
      end
   end

   // sequencer and command outcome
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pend_in    = rd_en;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = bst_pkg::STATUS_OK;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[AW-1:0];
      mem_wdata     = value_ff;

      if (rd_en) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end

      unique case (cmd_ff)
         bst_pkg::CMD_INSERT: begin
            if (full) begin
               rsp_status_in = bst_pkg::STATUS_FULL;
            end else if (hit_ff) begin
               rsp_status_in = bst_pkg::STATUS_DUP;
            end
         end
         bst_pkg::CMD_REMOVE: begin
            if (count_ff == '0) begin
               rsp_status_in = bst_pkg::STATUS_EMPTY;
            end else if (!hit_ff) begin
               rsp_status_in = bst_pkg::STATUS_ABSENT;
            end
            mem_waddr = pos_ff;
            mem_wdata = last_data_ff;
         end
         default: begin
            rsp_status_in = bst_pkg::STATUS_OK;
         end
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_idx_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == count_ff && !rd_pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (rsp_status_in == bst_pkg::STATUS_OK) begin
                  if (cmd_ff == bst_pkg::CMD_INSERT) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end else if (cmd_ff == bst_pkg::CMD_REMOVE) begin
                     mem_we   = 1'b1;
                     count_in = count_ff - CW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and scan results
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         hit_ff   <= 1'b0;
      end else if (rd_pend_ff) begin
         last_data_ff <= rd_data_ff;
         if (rd_data_ff == value_ff) begin
            hit_ff <= 1'b1;
            pos_ff <= cmp_idx_ff;
         end
      end
      if (rd_en) begin
         cmp_idx_ff <= rd_idx_ff[AW-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= hit_ff;
         rsp_count_ff  <= bst_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

### hw/rtl/bst_checker.sv
// port-level checks of the bounded set table, bound to the top level
// depends on bst_pkg and bounded_set_table_top_macros.svh
`include "bounded_set_table_top_macros.svh"

module bst_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [bst_pkg::STATUS_W-1:0]   rsp_status,
   input logic                           rsp_found,
   input logic [bst_pkg::COUNT_W-1:0]    rsp_count
);

   // a stalled response holds its payload
   `BST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_count))

   // duplicate implies the value was held
   `BST_ASSERT_IMPL(a_dup_found, clock, reset, rsp_valid && rsp_status == bst_pkg::STATUS_DUP, rsp_found)

   // absent implies the value was not held
   `BST_ASSERT_IMPL(a_absent_miss, clock, reset, rsp_valid && rsp_status == bst_pkg::STATUS_ABSENT, !rsp_found)

   // empty leaves an empty table and no hit
   `BST_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_valid && rsp_status == bst_pkg::STATUS_EMPTY, rsp_count == '0 && !rsp_found)

   // a request transfer never produces a response in the next cycle
   `BST_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))

endmodule

bind bounded_set_table_top bst_checker u_bst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_found  (rsp_found),
   .rsp_count  (rsp_count)
);

### verif/testbench.sv
// self-checking testbench for bounded_set_table_top: directed and random commands
// predicts status, found flag and count in a behavioural set model; needs bst_pkg
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_HELD = bst_pkg::MAX_ENTRIES_DEFAULT;
   // unused command encoding, behaves as a membership query
   localparam logic [bst_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int POOL_SIZE        = 24;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES    = 4;
   localparam int FINAL_SETTLE     = 30;
   localparam int WATCHDOG_LIMIT   = 500;
   localparam int RANDOM_PHASES    = 11;
   localparam int PHASE_ITEMS      = 170;

   typedef struct packed {
      logic [bst_pkg::STATUS_W-1:0] status;
      logic                         found;
      logic [bst_pkg::COUNT_W-1:0]  count;
   } outcome_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [bst_pkg::CMD_W-1:0]         req_cmd;
   logic signed [bst_pkg::VALUE_W-1:0] req_value;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [bst_pkg::STATUS_W-1:0]      rsp_status;
   logic                              rsp_found;
   logic [bst_pkg::COUNT_W-1:0]       rsp_count;
   logic                              csr_write_en;
   logic [bst_pkg::CAPACITY_W-1:0]    csr_write_data;

   // set model and outstanding predictions
   logic [bst_pkg::VALUE_W-1:0]    held_values[$];
   logic [bst_pkg::CAPACITY_W-1:0] cap_setting = bst_pkg::CAPACITY_RESET;
   outcome_type                    expected_outcomes[$];
   logic [bst_pkg::VALUE_W-1:0]    value_pool[POOL_SIZE];

   int   failures = 0;
   int   idle_cycles = 0;
   logic gaps_on = 1'b1;
   logic stall_on = 1'b1;
   logic long_hold_pending = 1'b0;

   bounded_set_table_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_count      (rsp_count),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // apply one command to the set model and return what the block should report
   function automatic outcome_type apply_command(input logic [bst_pkg::CMD_W-1:0] cmd,
                                                 input logic [bst_pkg::VALUE_W-1:0] value);
      outcome_type result;
      int          pos;
      int          limit;
      pos = -1;
      foreach (held_values[i]) begin
         if (pos < 0 && held_values[i] == value) pos = i;
      end
      limit = (cap_setting > MAX_HELD) ? MAX_HELD : int'(cap_setting);
      result.status = bst_pkg::STATUS_OK;
      case (cmd)
         bst_pkg::CMD_INSERT: begin
            // full takes precedence over duplicate
            if (held_values.size() >= limit) result.status = bst_pkg::STATUS_FULL;
            else if (pos >= 0) result.status = bst_pkg::STATUS_DUP;
            else held_values.push_back(value);
         end
         bst_pkg::CMD_REMOVE: begin
            if (held_values.size() == 0) result.status = bst_pkg::STATUS_EMPTY;
            else if (pos < 0) result.status = bst_pkg::STATUS_ABSENT;
            else held_values.delete(pos);
         end
         default: ;
      endcase
      result.found = (pos >= 0);
      result.count = bst_pkg::COUNT_W'(held_values.size());
      return result;
   endfunction

   // offer one request and record its prediction once the transfer happens
   task automatic send_item(input logic [bst_pkg::CMD_W-1:0] cmd,
                            input logic [bst_pkg::VALUE_W-1:0] value);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      expected_outcomes.push_back(apply_command(cmd, value));
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called while the block is idle
   task automatic write_capacity(input logic [bst_pkg::CAPACITY_W-1:0] cap);
      csr_write_data <= cap;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cap_setting = cap;
      @(posedge clock);
   endtask

   // small pool so that hits, duplicates and full tables are common
   task automatic refill_pool();
      foreach (value_pool[i]) value_pool[i] = $urandom();
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
   endtask

   task automatic send_random_item();
      int                          r;
      logic [bst_pkg::CMD_W-1:0]   cmd;
      logic [bst_pkg::VALUE_W-1:0] value;
      r = $urandom_range(0, 99);
      if (r < 45) cmd = bst_pkg::CMD_INSERT;
      else if (r < 80) cmd = bst_pkg::CMD_REMOVE;
      else if (r < 95) cmd = bst_pkg::CMD_QUERY;
      else cmd = CMD_SPARE;
      if (cmd == bst_pkg::CMD_REMOVE && held_values.size() > 0 && $urandom_range(0, 1) == 1)
         value = held_values[$urandom_range(0, held_values.size() - 1)];
      else if ($urandom_range(0, 6) == 0)
         value = $urandom();
      else
         value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_item(cmd, value);
   endtask

   // extremes of the value, every command, empty and absent cases
   task automatic test_directed();
      send_item(bst_pkg::CMD_QUERY,  32'h0000_0000);
      send_item(bst_pkg::CMD_REMOVE, 32'h0000_0000);
      send_item(bst_pkg::CMD_INSERT, 32'h8000_0000);
      send_item(bst_pkg::CMD_INSERT, 32'h7fff_ffff);
      send_item(bst_pkg::CMD_INSERT, 32'h0000_0000);
      send_item(bst_pkg::CMD_INSERT, 32'hffff_ffff);
      send_item(bst_pkg::CMD_INSERT, 32'h5555_5555);
      send_item(bst_pkg::CMD_INSERT, 32'haaaa_aaaa);
      send_item(bst_pkg::CMD_INSERT, 32'h8000_0000);
      send_item(bst_pkg::CMD_QUERY,  32'h7fff_ffff);
      send_item(bst_pkg::CMD_QUERY,  32'h0000_0001);
      send_item(CMD_SPARE,           32'h0000_0000);
      send_item(CMD_SPARE,           32'h1234_5678);
      send_item(bst_pkg::CMD_REMOVE, 32'h0000_0005);
      send_item(bst_pkg::CMD_REMOVE, 32'h0000_0000);
      send_item(bst_pkg::CMD_QUERY,  32'h0000_0000);
      send_item(bst_pkg::CMD_REMOVE, 32'h8000_0000);
      send_item(bst_pkg::CMD_REMOVE, 32'haaaa_aaaa);
      send_item(bst_pkg::CMD_QUERY,  32'h5555_5555);
      send_item(bst_pkg::CMD_INSERT, 32'h0000_0000);
      wait_until_idle();
   endtask

   // capacity zero, one, saturation above the depth and lowering below the count
   task automatic test_capacity_limits();
      logic [bst_pkg::VALUE_W-1:0] a;
      logic [bst_pkg::VALUE_W-1:0] b;
      a = $urandom();
      b = a ^ 32'h0000_0100;
      while (held_values.size() > 0)
         send_item(bst_pkg::CMD_REMOVE, held_values[$urandom_range(0, held_values.size() - 1)]);
      wait_until_idle();
      write_capacity(5'd0);
      send_item(bst_pkg::CMD_INSERT, a);
      send_item(bst_pkg::CMD_QUERY,  a);
      send_item(bst_pkg::CMD_REMOVE, a);
      wait_until_idle();
      write_capacity(5'd1);
      send_item(bst_pkg::CMD_INSERT, a);
      send_item(bst_pkg::CMD_INSERT, a);
      send_item(bst_pkg::CMD_INSERT, b);
      send_item(bst_pkg::CMD_REMOVE, b);
      send_item(bst_pkg::CMD_QUERY,  a);
      wait_until_idle();
      write_capacity(5'd31);
      while (held_values.size() < MAX_HELD) send_item(bst_pkg::CMD_INSERT, $urandom());
      send_item(bst_pkg::CMD_INSERT, b);
      send_item(bst_pkg::CMD_INSERT, a);
      wait_until_idle();
      write_capacity(5'd16);
      send_item(bst_pkg::CMD_INSERT, b);
      wait_until_idle();
      write_capacity(5'd3);
      send_item(bst_pkg::CMD_INSERT, b);
      send_item(bst_pkg::CMD_REMOVE, held_values[0]);
      send_item(bst_pkg::CMD_INSERT, b);
      wait_until_idle();
      write_capacity(5'd17);
      send_item(bst_pkg::CMD_INSERT, b);
      send_item(bst_pkg::CMD_INSERT, ~b);
      wait_until_idle();
   endtask

   // receiver holds off long enough for the block to stall its request side
   task automatic test_long_hold();
      refill_pool();
      long_hold_pending = 1'b1;
      repeat (12) send_random_item();
      wait_until_idle();
   endtask

   // sender stops until every response is back, then resumes
   task automatic test_pause();
      refill_pool();
      repeat (10) send_random_item();
      wait_until_idle();
      repeat (10) send_random_item();
      wait_until_idle();
   endtask

   // random phases, each with its own capacity and value pool
   task automatic test_random();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         refill_pool();
         if (phase == RANDOM_PHASES - 1) begin
            gaps_on  = 1'b0;
            stall_on = 1'b0;
         end else begin
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 9) == 0)
            write_capacity(bst_pkg::CAPACITY_W'($urandom_range(0, 31)));
         else
            write_capacity(bst_pkg::CAPACITY_W'($urandom_range(1, 16)));
         repeat (PHASE_ITEMS) send_random_item();
         wait_until_idle();
      end
   endtask

   // response side stall: short random bursts, or one long hold on request
   initial begin : rsp_stall_driver
      int burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_pending = 1'b0;
         end else if (stall_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin : response_check
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: response with nothing outstanding, status %0d found %0d count %0d",
                     $time, rsp_status, rsp_found, rsp_count);
            failures++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               failures++;
            end
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_found);
               failures++;
            end
            if (rsp_count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_count);
               failures++;
            end
         end
      end
   end

   // cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("bounded_set_table_top test failed");
            $finish;
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= bst_pkg::CMD_QUERY;
      req_value      <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity_limits();
      test_long_hold();
      test_pause();
      test_random();
      wait_until_idle();
      repeat (FINAL_SETTLE) @(posedge clock);
      if (failures == 0) begin
         $display("bounded_set_table_top test passed");
      end else begin
         $display("bounded_set_table_top test failed");
      end
      $finish;
   end

endmodule
